>>> rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

   localparam int DEF_BUFFER_BYTES = 65536;
   localparam int DEF_HEADER_BYTES = 12;
   localparam int DEF_MAX_SEGMENTS = 64;

   localparam int SEG_W  = 16;
   localparam int FREE_W = 17;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOFIT   = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
   localparam logic [1:0] STATUS_DOUBLE  = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [15:0] req_bytes;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [15:0]       block_addr;
      logic [FREE_W-1:0] free_bytes;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             free;
      logic [SEG_W-1:0] start;
      logic [SEG_W-1:0] size;
   } seg_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_PREV,
      CELL_NEXT,
      CELL_NEXT2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      seg_type     data;
   } cell_cmd_type;

   typedef struct packed {
      logic fit;
      logic hit;
   } cell_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_APPLY
   } state_type;

endpackage

`default_nettype wire

>>> rtl/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// One segment table entry: holds a segment, compares it against the current
// transaction and takes a new value from itself, a neighbor or a load.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_cell
   import ffsa_pkg::*;
#(
   parameter int      HEADER_BYTES = DEF_HEADER_BYTES,
   parameter seg_type RESET_SEG    = '0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cell_cmd_type   cmd_i,
   input  wire seg_type        prev_i,
   input  wire seg_type        next_i,
   input  wire seg_type        next2_i,
   input  wire logic [16:0]    rsize_i,
   input  wire logic [15:0]    address_i,
   output seg_type             seg_o,
   output cell_flags_type      flags_o
);

   localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);

   seg_type seg_ff;
   seg_type seg_in;

   always_comb begin
      case (cmd_i.op)
         CELL_HOLD:  seg_in = seg_ff;
         CELL_LOAD:  seg_in = cmd_i.data;
         CELL_PREV:  seg_in = prev_i;
         CELL_NEXT:  seg_in = next_i;
         CELL_NEXT2: seg_in = next2_i;
         default:    seg_in = seg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= RESET_SEG;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg_o       = seg_ff;
   assign flags_o.fit = seg_ff.valid && seg_ff.free && ({1'b0, seg_ff.size} >= rsize_i);
   assign flags_o.hit = seg_ff.valid && (({1'b0, seg_ff.start} + HDR17) == {1'b0, address_i});

endmodule

`default_nettype wire

>>> rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an address-ordered row of segment cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction on req_* carries an allocate (kind 0, req_bytes)
//   or a release (kind 1, address). Every request gives exactly one response
//   transaction on rsp_* with a status, the payload offset of an allocated
//   block and the free byte count after the operation.
//   Sequence: after acceptance, in the search state, all cells compare in parallel and a
//   priority select picks the first fitting (or matching) cell; in the update
//   state the cells shift by one or two places to split or merge segments
//   and the response is registered. A new request is taken in the update
//   state as the response is registered, so no request is taken while the
//   previous one is still being searched.
//   Reset leaves a single free segment spanning the buffer; no clearing pass
//   is needed since every cell has its own valid bit.
//   When rsp_stall holds a waiting response, the block finishes the search of
//   the next request and then waits before updating the table.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator
   import ffsa_pkg::*;
#(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int N     = MAX_SEGMENTS;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [SEG_W-1:0]  HDR16 = SEG_W'(HEADER_BYTES);
   localparam logic [16:0]       HDR17 = 17'(HEADER_BYTES);
   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_SEGMENTS);
   localparam logic [FREE_W-1:0] FREE_RESET = FREE_W'(BUFFER_BYTES - HEADER_BYTES);
   localparam seg_type FIRST_SEG = '{valid: 1'b1, free: 1'b1, start: '0,
                                     size: SEG_W'(BUFFER_BYTES - HEADER_BYTES)};

   state_type state_ff, state_in;

   logic        kind_ff;
   logic        req_zero_ff;
   logic [16:0] rsize_ff;
   logic [15:0] address_ff;

   logic [N-1:0] sel_ff;
   logic         found_ff;
   seg_type      sel_seg_ff, left_seg_ff, right_seg_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [FREE_W-1:0] free_ff, free_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   seg_type        segs  [N];
   cell_flags_type flags [N];
   cell_cmd_type   cmds  [N];

   logic [N-1:0] fit_vec, hit_vec, first_fit, sel_now;
   seg_type      sel_seg_now, left_seg_now, right_seg_now;

   logic out_free, apply_go, req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign apply_go   = (state_ff == ST_APPLY) && out_free;
   assign req_stall  = !((state_ff == ST_IDLE) || apply_go);
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------- cells
   for (genvar j = 0; j < N; j++) begin : g_cell
      seg_type prev_s, next_s, next2_s;
      if (j > 0) begin : g_p
         assign prev_s = segs[j-1];
      end else begin : g_np
         assign prev_s = '0;
      end
      if (j + 1 < N) begin : g_n
         assign next_s = segs[j+1];
      end else begin : g_nn
         assign next_s = '0;
      end
      if (j + 2 < N) begin : g_n2
         assign next2_s = segs[j+2];
      end else begin : g_nn2
         assign next2_s = '0;
      end

      ffsa_cell #(
         .HEADER_BYTES (HEADER_BYTES),
         .RESET_SEG    ((j == 0) ? FIRST_SEG : seg_type'('0))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd_i     (cmds[j]),
         .prev_i    (prev_s),
         .next_i    (next_s),
         .next2_i   (next2_s),
         .rsize_i   (rsize_ff),
         .address_i (address_ff),
         .seg_o     (segs[j]),
         .flags_o   (flags[j])
      );

      assign fit_vec[j] = flags[j].fit;
      assign hit_vec[j] = flags[j].hit;
   end

   // ------------------------------------------------------- search stage
   // Isolating the lowest set bit gives the first fit in address order.
   assign first_fit = fit_vec & (~fit_vec + {{(N-1){1'b0}}, 1'b1});
   assign sel_now   = (kind_ff == KIND_RELEASE) ? hit_vec : first_fit;

   always_comb begin
      sel_seg_now   = '0;
      left_seg_now  = '0;
      right_seg_now = '0;
      for (int j = 0; j < N; j++) begin
         if (sel_now[j]) begin
            sel_seg_now = sel_seg_now | segs[j];
            if (j > 0) begin
               left_seg_now = left_seg_now | segs[j-1];
            end
            if (j + 1 < N) begin
               right_seg_now = right_seg_now | segs[j+1];
            end
         end
      end
   end

   // -------------------------------------------------------- update stage
   logic         alloc_ok, split, rel_ok, merge_r, merge_l;
   logic [N-1:0] ge_mask, gt_mask, after_sel, before_sel;
   seg_type      data_a, data_b;

   assign alloc_ok = (kind_ff == KIND_ALLOC) && !req_zero_ff && found_ff;
   assign split    = alloc_ok && ({1'b0, sel_seg_ff.size} >= (rsize_ff + HDR17)) &&
                     (count_ff != CNT_FULL);
   assign rel_ok   = (kind_ff == KIND_RELEASE) && found_ff && !sel_seg_ff.free;
   assign merge_r  = rel_ok && right_seg_ff.valid && right_seg_ff.free;
   assign merge_l  = rel_ok && left_seg_ff.valid && left_seg_ff.free;

   assign ge_mask    = ~(sel_ff - {{(N-1){1'b0}}, 1'b1});
   assign gt_mask    = ge_mask & ~sel_ff;
   assign after_sel  = sel_ff << 1;
   assign before_sel = sel_ff >> 1;

   always_comb begin
      data_a = sel_seg_ff;
      data_b = sel_seg_ff;
      if (kind_ff == KIND_ALLOC) begin
         data_a.free = 1'b0;
         if (split) begin
            data_a.size  = rsize_ff[SEG_W-1:0];
            data_b.valid = 1'b1;
            data_b.free  = 1'b1;
            data_b.start = sel_seg_ff.start + HDR16 + rsize_ff[SEG_W-1:0];
            data_b.size  = sel_seg_ff.size - rsize_ff[SEG_W-1:0] - HDR16;
         end
      end else begin
         data_a.free = 1'b1;
         if (merge_r) begin
            data_a.size = sel_seg_ff.size + HDR16 + right_seg_ff.size;
         end
         // The left neighbor absorbs the released segment (and the right one).
         data_b      = left_seg_ff;
         data_b.size = left_seg_ff.size + HDR16 + sel_seg_ff.size;
         if (merge_r) begin
            data_b.size = left_seg_ff.size + HDR16 + sel_seg_ff.size + HDR16 +
                          right_seg_ff.size;
         end
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_cmd
      always_comb begin
         cmds[j].op   = CELL_HOLD;
         cmds[j].data = sel_ff[j] ? data_a : data_b;
         if (apply_go) begin
            if (alloc_ok) begin
               if (sel_ff[j]) begin
                  cmds[j].op = CELL_LOAD;
               end else if (split && after_sel[j]) begin
                  cmds[j].op = CELL_LOAD;
               end else if (split && gt_mask[j]) begin
                  cmds[j].op = CELL_PREV;
               end
            end else if (rel_ok) begin
               if (merge_l) begin
                  if (before_sel[j]) begin
                     cmds[j].op = CELL_LOAD;
                  end else if (ge_mask[j]) begin
                     cmds[j].op = merge_r ? CELL_NEXT2 : CELL_NEXT;
                  end
               end else begin
                  if (sel_ff[j]) begin
                     cmds[j].op = CELL_LOAD;
                  end else if (merge_r && gt_mask[j]) begin
                     cmds[j].op = CELL_NEXT;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      free_in  = free_ff;
      if (alloc_ok) begin
         if (split) begin
            count_in = count_ff + CNT_W'(1);
            free_in  = free_ff - rsize_ff - HDR17;
         end else begin
            free_in  = free_ff - {1'b0, sel_seg_ff.size};
         end
      end else if (rel_ok) begin
         free_in = free_ff + {1'b0, sel_seg_ff.size};
         if (merge_r && merge_l) begin
            count_in = count_ff - CNT_W'(2);
            free_in  = free_ff + {1'b0, sel_seg_ff.size} + HDR17 + HDR17;
         end else if (merge_r || merge_l) begin
            count_in = count_ff - CNT_W'(1);
            free_in  = free_ff + {1'b0, sel_seg_ff.size} + HDR17;
         end
      end

      rsp_data_in.free_bytes = free_in;
      rsp_data_in.block_addr = alloc_ok ? (sel_seg_ff.start + HDR16) : 16'd0;
      if (kind_ff == KIND_ALLOC) begin
         rsp_data_in.status = alloc_ok ? STATUS_OK : STATUS_NOFIT;
      end else if (!found_ff) begin
         rsp_data_in.status = STATUS_UNKNOWN;
      end else if (sel_seg_ff.free) begin
         rsp_data_in.status = STATUS_DOUBLE;
      end else begin
         rsp_data_in.status = STATUS_OK;
      end
   end

   // -------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in = req_accept ? ST_FIND : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(1);
         free_ff      <= FREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (apply_go) begin
            count_ff     <= count_in;
            free_ff      <= free_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff     <= req_data.kind;
         req_zero_ff <= (req_data.req_bytes == 16'd0);
         rsize_ff    <= ({1'b0, req_data.req_bytes} + 17'd3) & ~17'd3;
         address_ff  <= req_data.address;
      end
      if (state_ff == ST_FIND) begin
         sel_ff       <= sel_now;
         found_ff     <= |sel_now;
         sel_seg_ff   <= sel_seg_now;
         left_seg_ff  <= left_seg_now;
         right_seg_ff <= right_seg_now;
      end
      if (apply_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_checker
   import ffsa_pkg::*;
#(
   parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(BUFFER_BYTES - HEADER_BYTES);

   // A response waiting on the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // The table update follows the search, so requests are never taken
   // back to back.
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken in consecutive cycles");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.block_addr == 16'd0)
      else $error("failed transaction returned a block address");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_bytes <= FREE_MAX)
      else $error("free byte count exceeds buffer capacity");

endmodule

bind first_fit_segment_allocator ffsa_checker #(
   .BUFFER_BYTES (BUFFER_BYTES),
   .HEADER_BYTES (HEADER_BYTES)
) u_ffsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/first_fit_segment_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_test
// Drives allocate and release transactions with random idling and stalls,
// predicts each response from a behavioral segment table and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_segment_allocator_test;
   import ffsa_pkg::*;

   localparam int BUF_BYTES = DEF_BUFFER_BYTES;
   localparam int HDR_BYTES = DEF_HEADER_BYTES;
   localparam int MAX_SEGS  = DEF_MAX_SEGMENTS;
   localparam int NUM_RANDOM = 820;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      int unsigned start;
      int unsigned size;
      bit          is_free;
   } segment_t;

   class allocator_scoreboard;
      segment_t    segments[$];
      int unsigned free_total;
      rsp_type     pending[$];
      int          errors;
      int          checked;
      int          status_seen[4];

      function void clear();
         segment_t s;
         s.start = 0;
         s.size = BUF_BYTES - HDR_BYTES;
         s.is_free = 1;
         segments = {};
         segments.push_back(s);
         free_total = BUF_BYTES - HDR_BYTES;
      endfunction

      function rsp_type allocate(int unsigned bytes);
         rsp_type r;
         int unsigned rounded;
         int i;
         segment_t rest;
         rounded = (bytes + 3) & ~32'd3;
         r = '0;
         r.status = STATUS_NOFIT;
         if (bytes == 0) return r;
         for (i = 0; i < segments.size(); i++)
            if (segments[i].is_free && segments[i].size >= rounded) break;
         if (i >= segments.size()) return r;
         if (segments[i].size < rounded + HDR_BYTES || segments.size() >= MAX_SEGS) begin
            free_total -= segments[i].size;
            segments[i].is_free = 0;
         end else begin
            rest.start = segments[i].start + HDR_BYTES + rounded;
            rest.size = segments[i].size - rounded - HDR_BYTES;
            rest.is_free = 1;
            segments.insert(i + 1, rest);
            segments[i].size = rounded;
            segments[i].is_free = 0;
            free_total -= rounded + HDR_BYTES;
         end
         r.status = STATUS_OK;
         r.block_addr = 16'(segments[i].start + HDR_BYTES);
         return r;
      endfunction

      function logic [1:0] release_block(int unsigned addr);
         int i;
         for (i = 0; i < segments.size(); i++)
            if (segments[i].start + HDR_BYTES == addr) break;
         if (i >= segments.size()) return STATUS_UNKNOWN;
         if (segments[i].is_free) return STATUS_DOUBLE;
         segments[i].is_free = 1;
         free_total += segments[i].size;
         if (i + 1 < segments.size() && segments[i+1].is_free) begin
            segments[i].size += HDR_BYTES + segments[i+1].size;
            segments.delete(i + 1);
            free_total += HDR_BYTES;
         end
         if (i > 0 && segments[i-1].is_free) begin
            segments[i-1].size += HDR_BYTES + segments[i].size;
            segments.delete(i);
            free_total += HDR_BYTES;
         end
         return STATUS_OK;
      endfunction

      function void note_request(req_type q);
         rsp_type r;
         if (q.kind == KIND_ALLOC) r = allocate(32'(q.req_bytes));
         else begin
            r = '0;
            r.status = release_block(32'(q.address));
         end
         r.free_bytes = FREE_W'(free_total);
         pending.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected: %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         status_seen[got.status]++;
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.block_addr !== want.block_addr) begin
            $display("%0t: block_addr expected %0d actual %0d", $time,
                     want.block_addr, got.block_addr);
            errors++;
         end
         if (got.free_bytes !== want.free_bytes) begin
            $display("%0t: free_bytes expected %0d actual %0d", $time,
                     want.free_bytes, got.free_bytes);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   allocator_scoreboard board;
   int      cycles = 0;
   bit      calm = 0;
   int unsigned live_addrs[$];

   first_fit_segment_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   function bit idle_now();
      return !calm && ($urandom_range(99) < 31);
   endfunction

   // Watchdog and response side.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("first_fit_segment_allocator_test: FAIL");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
         rsp_stall <= idle_now();
      end
   end

   // Sends one transaction, with a random gap first. Valid stays high from
   // one transaction to the next unless a gap is inserted.
   task automatic send(logic kind, logic [15:0] bytes, logic [15:0] addr);
      req_type q;
      q.kind = kind;
      q.req_bytes = bytes;
      q.address = addr;
      if (idle_now()) begin
         req_valid <= 0;
         @(posedge clock);
         while (idle_now()) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      if (kind == KIND_ALLOC && board.pending[$].status == STATUS_OK)
         live_addrs.push_back(32'(board.pending[$].block_addr));
   endtask

   task automatic send_release_live();
      int k;
      k = $urandom_range(live_addrs.size() - 1);
      send(KIND_RELEASE, 16'($urandom), 16'(live_addrs[k]));
      live_addrs.delete(k);
   endtask

   initial begin
      int n;
      board = new();
      board.clear();
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed: zero request, extremes, small remainders, bad releases.
      send(KIND_ALLOC, 16'd0, 16'hFFFF);
      send(KIND_ALLOC, 16'hFFFF, 16'd0);
      send(KIND_RELEASE, 16'd0, 16'd0);
      send(KIND_RELEASE, 16'd0, 16'd12);
      send(KIND_ALLOC, 16'd1, 16'd0);
      send(KIND_ALLOC, 16'd5, 16'd0);
      send(KIND_ALLOC, 16'd100, 16'd0);
      send(KIND_RELEASE, 16'd0, 16'd12);
      send(KIND_RELEASE, 16'd0, 16'd12);
      send(KIND_RELEASE, 16'd0, 16'd13);
      send(KIND_ALLOC, 16'd4, 16'd0);
      // Leaves a header and 8 bytes behind, splitting off a free segment of 8 bytes.
      send(KIND_ALLOC, 16'(BUF_BYTES - HDR_BYTES - 16 - 16 - 112 - 2*HDR_BYTES), 16'd0);
      send(KIND_ALLOC, 16'd1, 16'd0);
      send(KIND_RELEASE, 16'd0, 16'd28);
      send(KIND_RELEASE, 16'd0, 16'd44);
      send(KIND_RELEASE, 16'd0, 16'hFFFF);
      while (live_addrs.size() > 0) send_release_live();
      send(KIND_ALLOC, 16'(BUF_BYTES - HDR_BYTES), 16'd0);
      while (live_addrs.size() > 0) send_release_live();

      // Random: mostly allocates and releases of live blocks, some noise.
      for (n = 0; n < NUM_RANDOM; n++) begin
         calm = (n >= 300 && n < 450);
         if (n % 250 == 200) begin
            // Fill the table with small blocks to reach the no-split case.
            repeat (MAX_SEGS + 4)
               send(KIND_ALLOC, 16'($urandom_range(1, 64)), 16'($urandom));
         end
         case ($urandom_range(9))
            0, 1, 2, 3: send(KIND_ALLOC,
                             16'(($urandom_range(3) == 0) ? $urandom
                                                          : $urandom_range(0, 3000)),
                             16'($urandom));
            4, 5, 6, 7:
               if (live_addrs.size() > 0) send_release_live();
               else send(KIND_ALLOC, 16'($urandom_range(1, 500)), 16'($urandom));
            8: send(KIND_RELEASE, 16'($urandom), 16'($urandom));
            default: send(KIND_RELEASE, 16'($urandom),
                          16'((live_addrs.size() > 0) ? live_addrs[0] + 4 : $urandom));
         endcase
      end
      calm = 0;
      req_valid <= 0;

      while (board.pending.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Checked %0d responses: %0d ok, %0d no fit, %0d unknown, %0d double release.",
               board.checked, board.status_seen[0], board.status_seen[1],
               board.status_seen[2], board.status_seen[3]);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("first_fit_segment_allocator_test: PASS");
      else
         $display("first_fit_segment_allocator_test: FAIL");
      $finish;
   end

endmodule
